// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KDAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define KDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/kdar_pkg.sv =====
package kdar_pkg;

    localparam int unsigned PIN_W   = 7;
    localparam int unsigned KEY_W   = 3;
    localparam int unsigned DELAY_W = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd400;
    localparam logic [DELAY_W-1:0] MILLIS_MAX  = 16'hFFFF;
    localparam logic [PIN_W-1:0]   PINS_IDLE   = 7'h7F;

    typedef enum logic [2:0] {
        OP_QUERY    = 3'd0,
        OP_SAMPLE1  = 3'd1,
        OP_SAMPLE2  = 3'd2,
        OP_MS_TICK  = 3'd3,
        OP_REP_TICK = 3'd4
    } t_opcode;

    typedef enum logic {
        REG_DELAY = 1'b0,
        REG_MASK  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [DELAY_W-1:0] repeat_delay;
        logic [PIN_W-1:0]   repeat_mask;
    } t_cfg;

    function automatic logic key_is_down(
        input logic [PIN_W-1:0] keys,
        input logic [KEY_W-1:0] k,
        input logic [KEY_W:0]   lim
    );
        logic [7:0] ext;
        ext = {1'b1, keys};
        return ({1'b0, k} < lim) && !ext[k];
    endfunction

endpackage

// ===== rtl/core/key_debounce_auto_repeat_unit.sv =====
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_ready   | i_opcode, i_raw_pins, i_key_index
// result  | out       | o_out_valid / i_out_ready | o_pressed, o_debounced_keys
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one beat in, one beat out; the result shows in the cycle after the input beat
// a new input beat is taken every cycle while the result register is empty or drained
// the result register holds under a stall and blocks input until taken
// synchronous active-low reset: key state released, delay 400, mask 0
// config is always ready and takes effect on the next beat
module key_debounce_auto_repeat_unit
    import kdar_pkg::*;
#(
    parameter int unsigned NUM_KEYS = 7
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic [PIN_W-1:0]   i_raw_pins,
    input  logic [KEY_W-1:0]   i_key_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_pressed,
    output logic [PIN_W-1:0]   o_debounced_keys,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [DELAY_W-1:0] i_cfg_data
);

    t_cfg             cfg;
    logic             accept;
    logic             res_pressed;
    logic [PIN_W-1:0] res_keys;
    logic             r_out_valid;
    logic             r_pressed;
    logic [PIN_W-1:0] r_keys;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    kdar_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    kdar_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_raw_pins  (i_raw_pins),
        .i_key_index (i_key_index),
        .i_cfg       (cfg),
        .o_pressed   (res_pressed),
        .o_keys      (res_keys)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pressed <= res_pressed;
            r_keys    <= res_keys;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pressed        = r_pressed;
    assign o_debounced_keys = r_keys;

endmodule

// ===== rtl/core/kdar_cfg.sv =====
module kdar_cfg
    import kdar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_index,
    input  logic [DELAY_W-1:0] i_cfg_data,
    output logic               o_cfg_ready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay <= DELAY_RESET;
            r_cfg.repeat_mask  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DELAY: r_cfg.repeat_delay <= i_cfg_data;
                REG_MASK:  r_cfg.repeat_mask  <= i_cfg_data[PIN_W-1:0];
                default:   r_cfg.repeat_delay <= r_cfg.repeat_delay;
            endcase
        end
    end

endmodule

// ===== rtl/core/kdar_core.sv =====
module kdar_core
    import kdar_pkg::*;
#(
    parameter int unsigned NUM_KEYS = 7
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_opcode,
    input  logic [PIN_W-1:0] i_raw_pins,
    input  logic [KEY_W-1:0] i_key_index,
    input  t_cfg             i_cfg,
    output logic             o_pressed,
    output logic [PIN_W-1:0] o_keys
);

    localparam logic [KEY_W:0] KEY_LIM = (KEY_W+1)'((NUM_KEYS < PIN_W) ? NUM_KEYS : PIN_W);

    logic [PIN_W-1:0]   r_stable, n_stable;
    logic [PIN_W-1:0]   r_first, n_first;
    logic               r_latched, n_latched;
    logic [KEY_W-1:0]   r_lkey, n_lkey;
    logic               r_armed, n_armed;
    logic [DELAY_W-1:0] r_millis, n_millis;
    logic               r_pending, n_pending;
    logic               pressed;
    logic               held;
    logic [7:0]         mask_ext;

    always_comb begin
        n_stable  = r_stable;
        n_first   = r_first;
        n_latched = r_latched;
        n_lkey    = r_lkey;
        n_armed   = r_armed;
        n_millis  = r_millis;
        n_pending = r_pending;
        pressed   = 1'b0;
        held      = 1'b0;
        mask_ext  = {1'b0, i_cfg.repeat_mask};
        unique case (t_opcode'(i_opcode))
            OP_QUERY: begin
                if (key_is_down(r_stable, i_key_index, KEY_LIM) && !r_latched) begin
                    n_latched = 1'b1;
                    n_lkey    = i_key_index;
                    pressed   = 1'b1;
                end
                held = key_is_down(r_stable, n_lkey, KEY_LIM);
                if (held && mask_ext[n_lkey] && (i_key_index == n_lkey)) begin
                    if (r_armed) begin
                        n_armed  = 1'b0;
                        n_millis = '0;
                    end
                    if ((n_millis >= i_cfg.repeat_delay) && r_pending) begin
                        n_pending = 1'b0;
                        pressed   = !pressed;
                    end
                end else if (!held) begin
                    n_latched = 1'b0;
                    n_armed   = 1'b1;
                end
            end
            OP_SAMPLE1: n_first = i_raw_pins;
            OP_SAMPLE2: begin
                if (i_raw_pins == r_first) begin
                    n_stable = i_raw_pins;
                end
            end
            OP_MS_TICK: begin
                if (r_millis != MILLIS_MAX) begin
                    n_millis = r_millis + 1'b1;
                end
            end
            OP_REP_TICK: n_pending = 1'b1;
            default: pressed = 1'b0;
        endcase
    end

    assign o_pressed = pressed;
    assign o_keys    = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable  <= PINS_IDLE;
            r_first   <= PINS_IDLE;
            r_latched <= 1'b0;
            r_lkey    <= '0;
            r_armed   <= 1'b1;
            r_millis  <= '0;
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_stable  <= n_stable;
            r_first   <= n_first;
            r_latched <= n_latched;
            r_lkey    <= n_lkey;
            r_armed   <= n_armed;
            r_millis  <= n_millis;
            r_pending <= n_pending;
        end
    end

endmodule

// ===== rtl/core/kdar_checker.sv =====
`include "assert_macros.svh"

module kdar_checker
    import kdar_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic [2:0]       i_opcode,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_pressed,
    input logic [PIN_W-1:0] o_debounced_keys
);

    `KDAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pressed) && $stable(o_debounced_keys))
    `KDAR_ASSERT_NEXT(a_beat_to_out, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)
    `KDAR_ASSERT_NEXT(a_press_query_only, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_opcode != OP_QUERY), !o_pressed)
    `KDAR_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

endmodule

bind key_debounce_auto_repeat_unit kdar_checker u_kdar_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_opcode         (i_opcode),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pressed        (o_pressed),
    .o_debounced_keys (o_debounced_keys)
);
